[rtl/btmx_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// btmx_pkg: shared types and constants for the binary trie max-XOR unit
// Sizes, operation and status codes, node entry layout, node store request.
// ----------------------------------------------------------------------------
package btmx_pkg;

  // sizes
  localparam int VALUE_BITS = 46;
  localparam int NODE_COUNT = 65536;
  localparam int LINK_W     = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int LVL_W      = $clog2(VALUE_BITS);

  typedef logic [LINK_W-1:0] link_t;

  // one node: child link for bit 1 and for bit 0, zero means absent
  typedef struct packed {
    link_t one;
    link_t zero;
  } entry_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POOL_FULL = 2'd1,
    STATUS_EMPTY     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_FINISH
  } state_e;

  // request from the walker to the node store
  typedef struct packed {
    logic   rd_en;
    link_t  rd_addr;
    logic   wr_en;
    link_t  wr_addr;
    entry_t wr_data;
    logic   clear;
  } node_req_t;

  // child link of a node for one key bit
  function automatic link_t link_sel(entry_t e, logic b);
    link_t l;
    l = b ? e.one : e.zero;
    return l;
  endfunction

endpackage
`default_nettype wire

[rtl/btmx_node_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// btmx_node_store: node table of the trie
// Node memory with one read and one write port, registered read data. The root
// node lives in a register that reset and clear zero.
// ----------------------------------------------------------------------------
module btmx_node_store (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire btmx_pkg::node_req_t req_i,
  output btmx_pkg::entry_t         rd_entry_o
);

  btmx_pkg::entry_t mem [btmx_pkg::NODE_COUNT];
  btmx_pkg::entry_t mem_rd_q;
  btmx_pkg::entry_t root_q;
  logic             rd_root_q;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && (req_i.wr_addr != '0)) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      mem_rd_q <= mem[req_i.rd_addr];
    end
  end

  // root node register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q    <= '0;
      rd_root_q <= 1'b1;
    end else begin
      if (req_i.clear) begin
        root_q <= '0;
      end else if (req_i.wr_en && (req_i.wr_addr == '0)) begin
        root_q <= req_i.wr_data;
      end
      if (req_i.rd_en) begin
        rd_root_q <= (req_i.rd_addr == '0);
      end
    end
  end

  assign rd_entry_o = rd_root_q ? root_q : mem_rd_q;

endmodule
`default_nettype wire

[rtl/binary_trie_max_xor_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit: maximum-XOR query over a binary trie
// Walker state machine, bit-serial key and result shifters, output register.
// ----------------------------------------------------------------------------
// One request at a time. The key enters a shift register and leaves it one bit
// per cycle, MSB first, while the walker follows one trie level per cycle
// through the node memory (its registered read sets that pace). A query walks
// from the root to a leaf; an insert that stores a value walks to the first
// missing node, then makes one memory write per new node plus the parent link;
// a duplicate insert walks to its leaf; a rejected insert on a full pool stops
// at the first missing node; an empty-trie query, clear and the unused
// operation skip the walk. A new request is taken while an earlier result
// still waits in the output register. No memory clearing pass is needed: the
// root sits in a register and every other node is written when allocated.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      operation_i,
  input  wire logic [btmx_pkg::VALUE_BITS-1:0] value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [btmx_pkg::VALUE_BITS-1:0]      max_xor_o,
  output logic [1:0]                           status_o
);

  localparam int VB = btmx_pkg::VALUE_BITS;

  btmx_pkg::state_e          state_q, state_d;
  btmx_pkg::op_e             op_q, op_d;
  logic [VB-1:0]             shift_q, shift_d;
  logic [VB-1:0]             acc_q, acc_d;
  logic [btmx_pkg::LVL_W-1:0] lvl_q, lvl_d;
  btmx_pkg::link_t           cur_q, cur_d;
  logic [btmx_pkg::CNT_W-1:0] nf_q, nf_d;
  logic                      empty_q, empty_d;
  logic                      first_q, first_d;
  logic                      tail_q, tail_d;
  btmx_pkg::status_e         pend_q, pend_d;
  logic                      out_valid_q, out_valid_d;
  logic [VB-1:0]             max_xor_q;
  btmx_pkg::status_e         status_q;
  logic                      out_load;

  btmx_pkg::node_req_t       req;
  btmx_pkg::entry_t          ent;
  btmx_pkg::entry_t          wdata;
  logic                      bit_cur;
  btmx_pkg::link_t           nx;
  btmx_pkg::link_t           opp;
  logic                      pool_full;
  logic [btmx_pkg::CNT_W:0]  need_sum;

  btmx_node_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rd_entry_o (ent)
  );

  // current key bit and the two candidate links
  assign bit_cur = shift_q[VB-1];
  assign nx      = btmx_pkg::link_sel(ent, bit_cur);
  assign opp     = btmx_pkg::link_sel(ent, ~bit_cur);

  // pool check: nodes in use plus nodes still missing must fit
  assign need_sum  = {1'b0, nf_q} + (btmx_pkg::CNT_W + 1)'(lvl_q)
                     + (btmx_pkg::CNT_W + 1)'(1);
  assign pool_full = need_sum > (btmx_pkg::CNT_W + 1)'(btmx_pkg::NODE_COUNT);

  // next state and walker control
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    shift_d  = shift_q;
    acc_d    = acc_q;
    lvl_d    = lvl_q;
    cur_d    = cur_q;
    nf_d     = nf_q;
    empty_d  = empty_q;
    first_d  = first_q;
    tail_d   = tail_q;
    pend_d   = pend_q;
    out_load = 1'b0;
    req      = '0;
    wdata    = '0;

    unique case (state_q)
      btmx_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = btmx_pkg::op_e'(operation_i);
          shift_d = value_i;
          acc_d   = '0;
          lvl_d   = btmx_pkg::LVL_W'(VB - 1);
          cur_d   = '0;
          first_d = 1'b0;
          tail_d  = 1'b0;
          pend_d  = btmx_pkg::STATUS_OK;
          unique case (btmx_pkg::op_e'(operation_i))
            btmx_pkg::OP_INSERT: begin
              req.rd_en   = 1'b1;
              req.rd_addr = '0;
              state_d     = btmx_pkg::ST_WALK;
            end
            btmx_pkg::OP_QUERY: begin
              if (empty_q) begin
                pend_d  = btmx_pkg::STATUS_EMPTY;
                state_d = btmx_pkg::ST_FINISH;
              end else begin
                req.rd_en   = 1'b1;
                req.rd_addr = '0;
                state_d     = btmx_pkg::ST_WALK;
              end
            end
            btmx_pkg::OP_CLEAR: begin
              req.clear = 1'b1;
              nf_d      = btmx_pkg::CNT_W'(1);
              empty_d   = 1'b1;
              state_d   = btmx_pkg::ST_FINISH;
            end
            btmx_pkg::OP_NONE: begin
              state_d = btmx_pkg::ST_FINISH;
            end
          endcase
        end
      end

      btmx_pkg::ST_WALK: begin
        if (op_q == btmx_pkg::OP_QUERY) begin
          // prefer the opposite branch, one result bit per level
          acc_d       = {acc_q[VB-2:0], (opp != '0)};
          shift_d     = {shift_q[VB-2:0], 1'b0};
          req.rd_en   = 1'b1;
          req.rd_addr = (opp != '0) ? opp : nx;
          if (lvl_q == '0) begin
            state_d = btmx_pkg::ST_FINISH;
          end else begin
            lvl_d = lvl_q - 1'b1;
          end
        end else if (nx == '0) begin
          // first missing node found
          if (pool_full) begin
            pend_d  = btmx_pkg::STATUS_POOL_FULL;
            state_d = btmx_pkg::ST_FINISH;
          end else begin
            first_d = 1'b1;
            state_d = btmx_pkg::ST_ALLOC;
          end
        end else begin
          cur_d       = nx;
          shift_d     = {shift_q[VB-2:0], 1'b0};
          req.rd_en   = 1'b1;
          req.rd_addr = nx;
          if (lvl_q == '0) begin
            // value already stored
            empty_d = 1'b0;
            state_d = btmx_pkg::ST_FINISH;
          end else begin
            lvl_d = lvl_q - 1'b1;
          end
        end
      end

      btmx_pkg::ST_ALLOC: begin
        req.wr_en   = 1'b1;
        req.wr_addr = cur_q;
        if (tail_q) begin
          // leaf node: no children
          req.wr_data = '0;
          empty_d     = 1'b0;
          state_d     = btmx_pkg::ST_FINISH;
        end else begin
          // parent keeps its other link, new nodes start empty
          wdata = first_q ? ent : '0;
          if (bit_cur) begin
            wdata.one = nf_q[btmx_pkg::LINK_W-1:0];
          end else begin
            wdata.zero = nf_q[btmx_pkg::LINK_W-1:0];
          end
          req.wr_data = wdata;
          cur_d       = nf_q[btmx_pkg::LINK_W-1:0];
          nf_d        = nf_q + 1'b1;
          shift_d     = {shift_q[VB-2:0], 1'b0};
          first_d     = 1'b0;
          if (lvl_q == '0) begin
            tail_d = 1'b1;
          end else begin
            lvl_d = lvl_q - 1'b1;
          end
        end
      end

      btmx_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = btmx_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign in_stall_o = (state_q != btmx_pkg::ST_IDLE);

  // output register handshake
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btmx_pkg::ST_IDLE;
      nf_q        <= btmx_pkg::CNT_W'(1);
      empty_q     <= 1'b1;
      first_q     <= 1'b0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nf_q        <= nf_d;
      empty_q     <= empty_d;
      first_q     <= first_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    shift_q <= shift_d;
    acc_q   <= acc_d;
    lvl_q   <= lvl_d;
    cur_q   <= cur_d;
    pend_q  <= pend_d;
    if (out_load) begin
      max_xor_q <= acc_q;
      status_q  <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_xor_o   = max_xor_q;
  assign status_o    = status_q;

  // node count stays within the pool
  a_nf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nf_q != '0) && (nf_q <= btmx_pkg::CNT_W'(btmx_pkg::NODE_COUNT)))
    else $error("free node counter out of range");

  // allocation writes only nodes already handed out
  a_alloc_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == btmx_pkg::ST_ALLOC) |-> ({1'b0, cur_q} < nf_q))
    else $error("allocation writes an unallocated node");

  // a query never walks an empty trie
  a_query_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == btmx_pkg::ST_WALK && op_q == btmx_pkg::OP_QUERY) |-> !empty_q)
    else $error("query walk on empty trie");

  // flagged results carry a zero value
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != 2'(btmx_pkg::STATUS_OK)) |-> (max_xor_o == '0))
    else $error("flagged result with nonzero value");

endmodule
`default_nettype wire

[tb/sv/binary_trie_max_xor_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit_tb: self-checking bench for the max-XOR trie unit
// A directed table covers the empty trie, the operation codes and the extreme
// keys. Random phases then mix inserts, queries, clears and the unused
// operation. Every result is checked against a hand-written expectation or
// a behavioral trie kept inside the bench.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_unit_tb;

  typedef logic [btmx_pkg::VALUE_BITS-1:0] value_t;

  // one result: max xor and status
  typedef struct packed {
    value_t            xr;
    btmx_pkg::status_e st;
  } outcome_t;

  // one row of the directed table; typed_ok marks a hand-written expectation
  typedef struct packed {
    btmx_pkg::op_e     op;
    value_t            value;
    logic              typed_ok;
    value_t            xr;
    btmx_pkg::status_e st;
  } plan_row_t;

  localparam value_t ONES         = '1;
  localparam value_t TOP          = value_t'(1) << (btmx_pkg::VALUE_BITS - 1);
  localparam value_t ALT_HI       = 46'h2AAA_AAAA_AAAA;
  localparam value_t ALT_LO       = 46'h1555_5555_5555;
  localparam int     QUIET_LIMIT  = 1000;
  localparam int     DRAIN_CYCLES = 64;
  localparam int     PHASE_ITEMS  = 106;
  localparam int     KEPT_MAX     = 256;

  // idling modes
  localparam int     IDLE_NONE    = 0;
  localparam int     IDLE_FULL    = 1;
  localparam int     IDLE_SOME    = 2;

  // directed table: empty trie, extremes, every operation
  localparam int        PLAN_ROWS = 25;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{btmx_pkg::OP_QUERY,  '0,     1'b1, '0,   btmx_pkg::STATUS_EMPTY},
    '{btmx_pkg::OP_QUERY,  ONES,   1'b1, '0,   btmx_pkg::STATUS_EMPTY},
    '{btmx_pkg::OP_NONE,   ONES,   1'b1, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_CLEAR,  '0,     1'b1, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_INSERT, '0,     1'b1, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_QUERY,  ONES,   1'b1, ONES, btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_QUERY,  '0,     1'b1, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_INSERT, ONES,   1'b1, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_QUERY,  '0,     1'b1, ONES, btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_QUERY,  ONES,   1'b1, ONES, btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_INSERT, ONES,   1'b1, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_INSERT, '0,     1'b1, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_QUERY,  ALT_HI, 1'b0, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_INSERT, ALT_LO, 1'b0, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_QUERY,  ALT_LO, 1'b0, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_NONE,   '0,     1'b1, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_QUERY,  TOP,    1'b0, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_CLEAR,  ONES,   1'b1, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_QUERY,  TOP,    1'b1, '0,   btmx_pkg::STATUS_EMPTY},
    '{btmx_pkg::OP_INSERT, TOP,    1'b1, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_QUERY,  TOP,    1'b1, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_QUERY,  '0,     1'b1, TOP,  btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_INSERT, 46'd1,  1'b0, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_QUERY,  ONES,   1'b0, '0,   btmx_pkg::STATUS_OK},
    '{btmx_pkg::OP_CLEAR,  '0,     1'b1, '0,   btmx_pkg::STATUS_OK}
  };

  logic clk_i = 1'b0;
  logic rst_n;
  logic in_valid_q;
  logic [1:0] operation_q;
  value_t value_q;
  logic out_stall_q;

  logic in_stall_o;
  logic out_valid_o;
  value_t max_xor_o;
  logic [1:0] status_o;

  // behavioral trie
  btmx_pkg::link_t trie_zero [btmx_pkg::NODE_COUNT];
  btmx_pkg::link_t trie_one [btmx_pkg::NODE_COUNT];
  int unsigned trie_used;
  bit trie_empty;

  outcome_t owed_results [$];
  value_t kept_values [$];
  outcome_t last_pred;
  int idle_mode;
  int bad_results = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  binary_trie_max_xor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_q),
    .value_i     (value_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_q),
    .max_xor_o   (max_xor_o),
    .status_o    (status_o)
  );

  always #1 clk_i = ~clk_i;

  // apply one request to the trie and return the result it owes
  function automatic outcome_t trie_apply(btmx_pkg::op_e op, value_t v);
    outcome_t res;
    int unsigned node, nxt, need;
    bit walking;
    res.xr = '0;
    res.st = btmx_pkg::STATUS_OK;
    case (op)
      btmx_pkg::OP_INSERT: begin
        // count the nodes this value is missing
        node = 0;
        need = 0;
        walking = 1'b1;
        for (int i = btmx_pkg::VALUE_BITS - 1; i >= 0; i--) begin
          if (walking) begin
            nxt = v[i] ? trie_one[node] : trie_zero[node];
            if (nxt == 0) begin
              need = i + 1;
              walking = 1'b0;
            end else begin
              node = nxt;
            end
          end
        end
        if (need > btmx_pkg::NODE_COUNT - trie_used) begin
          res.st = btmx_pkg::STATUS_POOL_FULL;
        end else begin
          node = 0;
          for (int i = btmx_pkg::VALUE_BITS - 1; i >= 0; i--) begin
            nxt = v[i] ? trie_one[node] : trie_zero[node];
            if (nxt == 0) begin
              nxt = trie_used;
              trie_used++;
              trie_zero[nxt] = '0;
              trie_one[nxt] = '0;
              if (v[i]) trie_one[node] = btmx_pkg::link_t'(nxt);
              else trie_zero[node] = btmx_pkg::link_t'(nxt);
            end
            node = nxt;
          end
          trie_empty = 1'b0;
        end
      end
      btmx_pkg::OP_QUERY: begin
        if (trie_empty) begin
          res.st = btmx_pkg::STATUS_EMPTY;
        end else begin
          // greedy walk: prefer the branch opposite to the key bit
          node = 0;
          for (int i = btmx_pkg::VALUE_BITS - 1; i >= 0; i--) begin
            nxt = v[i] ? trie_zero[node] : trie_one[node];
            if (nxt != 0) begin
              res.xr[i] = 1'b1;
              node = nxt;
            end else begin
              node = v[i] ? trie_one[node] : trie_zero[node];
            end
          end
        end
      end
      btmx_pkg::OP_CLEAR: begin
        trie_zero[0] = '0;
        trie_one[0] = '0;
        trie_used = 1;
        trie_empty = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // wait cycles for one request or result, by the current idling mode
  function automatic int idle_draw();
    int n;
    case (idle_mode)
      IDLE_NONE: n = 0;
      IDLE_FULL: n = $urandom_range(0, 15);
      default: n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endcase
    return n;
  endfunction

  // random key, often built from a value already stored
  function automatic value_t make_key();
    value_t v, kept;
    int pick;
    v = value_t'({$urandom(), $urandom()});
    kept = v;
    if (kept_values.size() != 0) kept = kept_values[$urandom_range(0, kept_values.size() - 1)];
    pick = $urandom_range(0, 9);
    case (pick)
      0: v = '0;
      1: v = ONES;
      2: v = value_t'(1) << $urandom_range(0, btmx_pkg::VALUE_BITS - 1);
      5: v = kept;
      6: v = ~kept;
      7: v = kept ^ (value_t'(1) << $urandom_range(0, btmx_pkg::VALUE_BITS - 1));
      8: v = kept ^ (v & value_t'(8'hFF));
      default: ;
    endcase
    return v;
  endfunction

  // send one request; predict its result when it is taken
  task automatic issue(input btmx_pkg::op_e op, input value_t v, input logic typed_ok,
                       input outcome_t typed);
    int gap;
    outcome_t owed;
    gap = idle_draw();
    while (gap > 0) begin
      in_valid_q <= 1'b0;
      @(posedge clk_i);
      gap--;
    end
    in_valid_q <= 1'b1;
    operation_q <= op;
    value_q <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    last_pred = trie_apply(op, v);
    owed = typed_ok ? typed : last_pred;
    owed_results = {owed_results, owed};
    // remember stored values to aim later keys at
    if (op == btmx_pkg::OP_CLEAR) begin
      kept_values.delete();
    end else if (op == btmx_pkg::OP_INSERT && last_pred.st == btmx_pkg::STATUS_OK) begin
      kept_values = {kept_values, v};
      if (kept_values.size() > KEPT_MAX) kept_values.delete(0);
    end
  endtask

  // hold the sender until every owed result has come back
  task automatic drain_pause();
    while (owed_results.size() != 0) begin
      in_valid_q <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // one random phase of mixed requests
  task automatic random_phase(input int clear_pct);
    int roll;
    btmx_pkg::op_e op;
    drain_pause();
    repeat (PHASE_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < clear_pct) op = btmx_pkg::OP_CLEAR;
      else if (roll < clear_pct + 3) op = btmx_pkg::OP_NONE;
      else if (roll < 45) op = btmx_pkg::OP_INSERT;
      else op = btmx_pkg::OP_QUERY;
      issue(op, make_key(), 1'b0, '0);
    end
  endtask

  // result side: random stalls, then check against the oldest expectation
  initial begin : result_side
    int hold;
    outcome_t want;
    out_stall_q = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = idle_draw();
      out_stall_q <= (hold != 0);
      @(posedge clk_i);
      while (!(out_valid_o && !out_stall_q)) begin
        if (out_valid_o && hold > 0) hold--;
        out_stall_q <= (hold != 0);
        @(posedge clk_i);
      end
      results_seen++;
      if (owed_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("result %0d arrived with nothing owed: max_xor=%h status=%0d",
                   results_seen, max_xor_o, status_o);
      end else begin
        want = owed_results.pop_front();
        if (max_xor_o !== want.xr || status_o !== want.st) begin
          bad_results++;
          if (bad_results <= 10)
            $display("result %0d: expected max_xor=%h status=%0d, got max_xor=%h status=%0d",
                     results_seen, want.xr, want.st, max_xor_o, status_o);
        end
      end
    end
  end

  // watchdog: ends the run when neither side moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_q && !in_stall_o) || (out_valid_o && !out_stall_q)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : request_side
    outcome_t typed;
    rst_n = 1'b0;
    in_valid_q = 1'b0;
    operation_q = btmx_pkg::OP_NONE;
    value_q = '0;
    idle_mode = IDLE_SOME;
    trie_zero[0] = '0;
    trie_one[0] = '0;
    trie_used = 1;
    trie_empty = 1'b1;

    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      typed.xr = PLAN[i].xr;
      typed.st = PLAN[i].st;
      issue(PLAN[i].op, PLAN[i].value, PLAN[i].typed_ok, typed);
    end

    // random phases, each with its own idling and clear rate
    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = $urandom_range(IDLE_NONE, IDLE_SOME);
      case ($urandom_range(0, 2))
        0: random_phase(0);
        1: random_phase(2);
        default: random_phase(6);
      endcase
    end

    // wait for the tail, then a little longer for anything unowed
    in_valid_q <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_results == 0 && owed_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
